// ===== rtl/pcrmf_pkg.sv =====
// ----------------------------------------------------------------------------
// pcrmf_pkg
// Shared types and constants for the per-channel RSSI median floor block.
// ----------------------------------------------------------------------------
package pcrmf_pkg;

  localparam int SAMPLE_W = 8;
  localparam int OP_W     = 2;
  localparam int CHAN_W   = 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Floor value loaded on reset (dBm).
  localparam sample_t FLOOR_RESET = -8'sd90;

  // Operation codes; the unused code behaves as a query.
  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_QUERY  = 2'd1,
    OP_REFILL = 2'd2
  } op_t;

endpackage

// ===== rtl/per_channel_rssi_median_floor.sv =====
// ----------------------------------------------------------------------------
// per_channel_rssi_median_floor
// Running median of the last HISTORY_DEPTH RSSI readings, one ring per channel.
// ----------------------------------------------------------------------------
// Pipeline: at input accept the row is read into stage 1; stage 1 then does the
//   merge/write-back/median into the output register.
// Throughput: one word per cycle unless out_ready stalls the output; the row
//   memory is read once at accept and written back at most once when stage 1
//   advances, with a bypass register covering back-to-back hits on one channel.
// Reset: synchronous; every ring reads as -90 dBm and every write position
//   as zero at once (per-row valid flags), so no clearing pass is needed.
// ----------------------------------------------------------------------------
module per_channel_rssi_median_floor #(
  parameter int NUM_CHANNELS  = 16,
  parameter int HISTORY_DEPTH = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: initial floor register
  input  logic                          cfg_wr_en,
  input  logic [pcrmf_pkg::SAMPLE_W-1:0] cfg_wr_data,
  // input word
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pcrmf_pkg::OP_W-1:0]     operation,
  input  logic [pcrmf_pkg::CHAN_W-1:0]   channel,
  input  logic signed [pcrmf_pkg::SAMPLE_W-1:0] reading,
  // result word
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [pcrmf_pkg::SAMPLE_W-1:0] floor_estimate
);

  localparam int ADDR_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int MED_IDX = HISTORY_DEPTH / 2;

  // One memory row holds a channel's whole ring plus its write position.
  typedef struct packed {
    logic [SLOT_W-1:0]                           slot;
    pcrmf_pkg::sample_t [HISTORY_DEPTH-1:0]      samples;
  } row_t;

  // --------------------------------------------------------------------------
  // Configuration register and the value captured by the last refill.
  // Rows with a cleared sample flag read as fill_value; rows with a cleared
  // slot flag read position zero. Refill clears only the sample flags.
  // --------------------------------------------------------------------------
  pcrmf_pkg::sample_t initial_floor;
  pcrmf_pkg::sample_t fill_value;
  logic [NUM_CHANNELS-1:0] sample_valid;
  logic [NUM_CHANNELS-1:0] slot_valid;

  // Stage 1 (memory read data available)
  logic               s1_valid;
  pcrmf_pkg::op_t     s1_op;
  logic [ADDR_W-1:0]  s1_addr;
  logic               s1_in_range;
  pcrmf_pkg::sample_t s1_reading;
  row_t               rd_row;

  // Bypass of the most recent write-back
  logic               byp_valid;
  logic [ADDR_W-1:0]  byp_addr;
  row_t               byp_row;

  row_t mem [NUM_CHANNELS];

  logic               in_accept;
  logic               s1_advance;
  logic               wr_en;
  logic [ADDR_W-1:0]  in_addr;
  logic               in_range;

  row_t               src_row;
  row_t               cur_row;
  row_t               new_row;
  logic [SLOT_W-1:0]  pos;
  pcrmf_pkg::sample_t [HISTORY_DEPTH-1:0] med_samples;
  logic [CNT_W-1:0]   rank [HISTORY_DEPTH];
  pcrmf_pkg::sample_t median;
  pcrmf_pkg::sample_t result;

  // --------------------------------------------------------------------------
  // Handshake: stage 1 moves on whenever the output register is free.
  // --------------------------------------------------------------------------
  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;
  assign in_accept  = in_valid && in_ready;

  assign in_addr  = ADDR_W'(channel);
  assign in_range = (32'(channel) < NUM_CHANNELS);

  // Only adds to a real channel touch the memory.
  assign wr_en = s1_valid && s1_advance && s1_in_range && (s1_op == pcrmf_pkg::OP_ADD);

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_floor <= pcrmf_pkg::FLOOR_RESET;
    end else if (cfg_wr_en) begin
      initial_floor <= cfg_wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // Row memory: read at accept, written back from stage 1.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr] <= new_row;
    end
    if (in_accept) begin
      rd_row <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      case (operation)
        pcrmf_pkg::OP_ADD:    s1_op <= pcrmf_pkg::OP_ADD;
        pcrmf_pkg::OP_REFILL: s1_op <= pcrmf_pkg::OP_REFILL;
        default:              s1_op <= pcrmf_pkg::OP_QUERY;
      endcase
      s1_addr     <= in_addr;
      s1_in_range <= in_range;
      s1_reading  <= reading;
    end
  end

  // Valid flags, refill capture and bypass register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= '0;
      slot_valid   <= '0;
      fill_value   <= pcrmf_pkg::FLOOR_RESET;
      byp_valid    <= 1'b0;
    end else begin
      if (s1_valid && s1_advance && (s1_op == pcrmf_pkg::OP_REFILL)) begin
        sample_valid <= '0;
        fill_value   <= initial_floor;
      end else if (wr_en) begin
        sample_valid[s1_addr] <= 1'b1;
      end
      if (wr_en) begin
        slot_valid[s1_addr] <= 1'b1;
        byp_valid           <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      byp_addr <= s1_addr;
      byp_row  <= new_row;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: resolve the current row, apply the add, rank for the median.
  // --------------------------------------------------------------------------
  always_comb begin
    src_row = (byp_valid && (byp_addr == s1_addr)) ? byp_row : rd_row;
    cur_row.samples = sample_valid[s1_addr] ? src_row.samples
                                            : {HISTORY_DEPTH{fill_value}};
    cur_row.slot    = slot_valid[s1_addr] ? src_row.slot : '0;
  end

  assign pos = (32'(cur_row.slot) >= HISTORY_DEPTH) ? '0 : cur_row.slot;

  always_comb begin
    new_row = cur_row;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (pos == SLOT_W'(i)) begin
        new_row.samples[i] = s1_reading;
      end
    end
    new_row.slot = (pos == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : pos + SLOT_W'(1);
  end

  assign med_samples = (s1_op == pcrmf_pkg::OP_ADD) ? new_row.samples : cur_row.samples;

  // Rank each slot: count smaller values, ties broken by slot index.
  always_comb begin
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      rank[i] = '0;
      for (int j = 0; j < HISTORY_DEPTH; j++) begin
        if ((j != i) &&
            (($signed(med_samples[j]) < $signed(med_samples[i])) ||
             ((med_samples[j] == med_samples[i]) && (j < i)))) begin
          rank[i] = rank[i] + CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    median = med_samples[0];
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (rank[i] == CNT_W'(MED_IDX)) begin
        median = med_samples[i];
      end
    end
  end

  // A refill leaves every ring at the floor, so its median is the floor.
  assign result = (!s1_in_range || (s1_op == pcrmf_pkg::OP_REFILL)) ? initial_floor : median;

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_advance) begin
      floor_estimate <= result;
    end
  end

endmodule

// ===== rtl/pcrmf_checker.sv =====
// ----------------------------------------------------------------------------
// pcrmf_checker
// Port-level checks for the per-channel RSSI median floor block.
// ----------------------------------------------------------------------------
module pcrmf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pcrmf_pkg::SAMPLE_W-1:0] floor_estimate
);

  // Empty pipeline right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("pipeline not empty after reset");

  // Input stalls only behind a stalled result word.
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  // A new result word needs an earlier accepted input word.
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result word without a matching input word");

  // Stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(floor_estimate)))
    else $error("stalled result word changed");

endmodule

bind per_channel_rssi_median_floor pcrmf_checker u_pcrmf_checker (.*);
